// ===== rtl/core/cfb_pkg.sv =====
// Shared types and constants for the clipped fill and blit framebuffer.
// No dependencies; used by every module under rtl/core.
package cfb_pkg;

    localparam int DIM_W     = 9;
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 32;
    localparam int KIND_W    = 3;
    localparam int DEST_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DEPTH = 4;

    localparam int MAX_STRIDE_DEF = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    localparam logic [KIND_W-1:0] KIND_PUT        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FILL       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLIT_START = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BLIT_PIX   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] stride;
        logic             ok;
    } cfb_cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic       hit;
    } cfb_ctl_t;

endpackage

// ===== rtl/core/clipped_fill_blit_framebuffer_top.sv =====
// Top level of the clipped fill and blit framebuffer engine.
// Holds the frame registers and read credits; uses cfb_pkg, cfb_ctrl,
// cfb_addr, cfb_store and cfb_outq.
//
//   channel   prefix   direction   content
//   input     s_       in          kind, pos_x, pos_y, rect_w, rect_h, pixel_value
//   result    m_       out         read_value, read_inside (read kind only)
//   config    cfg_     in          register index and 9-bit write data
//
// Put, blit start, blit pixel and read are each taken in a single transfer; a fill holds
// s_ready low while it writes its clipped pixels in turn through the single write port of the store.
// m_valid for a read rises once the store result is queued in cfb_outq; at most OUT_DEPTH
// reads may be outstanding before s_ready drops, so a stalled m_ channel backs up.
// Reset is synchronous, active low; the pixel store has no clearing pass.
module clipped_fill_blit_framebuffer_top #(
    parameter int MAX_STRIDE = cfb_pkg::MAX_STRIDE_DEF,
    parameter int MAX_HEIGHT = cfb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfb_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cfb_pkg::KIND_W-1:0]    s_kind,
    input  logic [cfb_pkg::COORD_W-1:0]   s_pos_x,
    input  logic [cfb_pkg::COORD_W-1:0]   s_pos_y,
    input  logic [cfb_pkg::COORD_W-1:0]   s_rect_w,
    input  logic [cfb_pkg::COORD_W-1:0]   s_rect_h,
    input  logic [cfb_pkg::PIX_W-1:0]     s_pixel_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cfb_pkg::PIX_W-1:0]     m_read_value,
    output logic                          m_read_inside
);

    localparam int ADDR_W = $clog2(MAX_STRIDE * MAX_HEIGHT);
    localparam int CNT_W  = $clog2(cfb_pkg::OUT_DEPTH + 1);

    logic [cfb_pkg::DIM_W-1:0] width_reg, height_reg, stride_reg;
    cfb_pkg::cfb_cfg_t         cfg;
    logic [CNT_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                      credit_ok;
    logic                      rd_take;
    logic                      m_take;

    cfb_pkg::cfb_ctl_t         a_ctl, b_ctl;
    logic [cfb_pkg::DIM_W-1:0] a_x, a_y;
    logic [cfb_pkg::PIX_W-1:0] a_data, b_data, rd_data;
    logic [ADDR_W-1:0]         b_addr;
    logic                      rd_valid, rd_inside;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cfb_pkg::DIM_RESET;
            height_reg <= cfb_pkg::DIM_RESET;
            stride_reg <= cfb_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cfb_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                cfb_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                cfb_pkg::CFG_STRIDE: stride_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.stride = stride_reg;
    assign cfg.ok     = (width_reg != '0) && (height_reg != '0)
                        && (stride_reg >= width_reg)
                        && (32'(stride_reg) <= 32'(MAX_STRIDE))
                        && (32'(height_reg) <= 32'(MAX_HEIGHT));

    assign rd_take   = s_valid && s_ready && (s_kind == cfb_pkg::KIND_READ);
    assign m_take    = m_valid && m_ready;
    assign credit_ok = rd_cnt_reg < CNT_W'(cfb_pkg::OUT_DEPTH);

    always_comb begin
        priority if (rd_take && !m_take) begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end else if (m_take && !rd_take) begin
            rd_cnt_next = rd_cnt_reg - CNT_W'(1);
        end else begin
            rd_cnt_next = rd_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg <= '0;
        end else begin
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    cfb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .credit_ok     (credit_ok),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_rect_w      (s_rect_w),
        .s_rect_h      (s_rect_h),
        .s_pixel_value (s_pixel_value),
        .a_ctl         (a_ctl),
        .a_x           (a_x),
        .a_y           (a_y),
        .a_data        (a_data)
    );

    cfb_addr #(
        .MAX_STRIDE (MAX_STRIDE),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_addr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stride  (stride_reg),
        .a_ctl   (a_ctl),
        .a_x     (a_x),
        .a_y     (a_y),
        .a_data  (a_data),
        .b_ctl   (b_ctl),
        .b_addr  (b_addr),
        .b_data  (b_data)
    );

    cfb_store #(
        .MAX_STRIDE (MAX_STRIDE),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .b_ctl     (b_ctl),
        .b_addr    (b_addr),
        .b_data    (b_data),
        .rd_valid  (rd_valid),
        .rd_inside (rd_inside),
        .rd_data   (rd_data)
    );

    cfb_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (rd_valid),
        .push_inside   (rd_inside),
        .push_data     (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_read_inside (m_read_inside)
    );

    // read credits cover every result in flight or queued
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_cnt_reg <= CNT_W'(cfb_pkg::OUT_DEPTH))
        else $error("read credit count above queue depth");

    a_result_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> rd_cnt_reg != '0)
        else $error("result presented with no outstanding read");

    a_read_takes_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_take |=> rd_cnt_reg != '0)
        else $error("read transfer did not claim a credit");

    a_ready_needs_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> rd_cnt_reg < CNT_W'(cfb_pkg::OUT_DEPTH))
        else $error("input ready with queue credits exhausted");

endmodule

// ===== rtl/core/cfb_ctrl.sv =====
// Operation decode, fill walker and blit position tracking.
// Emits at most one store access per cycle into the address stage. Depends on cfb_pkg.
module cfb_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfb_pkg::cfb_cfg_t             cfg,
    input  logic                          credit_ok,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cfb_pkg::KIND_W-1:0]    s_kind,
    input  logic [cfb_pkg::COORD_W-1:0]   s_pos_x,
    input  logic [cfb_pkg::COORD_W-1:0]   s_pos_y,
    input  logic [cfb_pkg::COORD_W-1:0]   s_rect_w,
    input  logic [cfb_pkg::COORD_W-1:0]   s_rect_h,
    input  logic [cfb_pkg::PIX_W-1:0]     s_pixel_value,
    output cfb_pkg::cfb_ctl_t             a_ctl,
    output logic [cfb_pkg::DIM_W-1:0]     a_x,
    output logic [cfb_pkg::DIM_W-1:0]     a_y,
    output logic [cfb_pkg::PIX_W-1:0]     a_data
);

    localparam int DW = cfb_pkg::DIM_W;
    localparam int CW = cfb_pkg::COORD_W;

    logic              fill_busy_reg, fill_busy_next;
    logic [DW-1:0]     fill_x_reg, fill_x_next;
    logic [DW-1:0]     fill_y_reg, fill_y_next;
    logic [DW-1:0]     fill_w_reg, fill_w_next;
    logic [DW-1:0]     fill_h_reg, fill_h_next;
    logic [DW-1:0]     fill_c_reg, fill_c_next;
    logic [DW-1:0]     fill_r_reg, fill_r_next;
    logic [cfb_pkg::PIX_W-1:0] fill_pix_reg, fill_pix_next;

    logic              blit_active_reg, blit_active_next;
    logic [cfb_pkg::DEST_W-1:0] blit_dx_reg, blit_dx_next;
    logic [cfb_pkg::DEST_W-1:0] blit_dy_reg, blit_dy_next;
    logic [CW-1:0]     blit_sw_reg, blit_sw_next;
    logic [CW-1:0]     blit_sh_reg, blit_sh_next;
    logic [DW-1:0]     blit_cw_reg, blit_cw_next;
    logic [DW-1:0]     blit_ch_reg, blit_ch_next;
    logic [CW-1:0]     blit_row_reg, blit_row_next;
    logic [CW-1:0]     blit_col_reg, blit_col_next;

    cfb_pkg::cfb_ctl_t a_ctl_reg, a_ctl_next;
    logic [DW-1:0]     a_x_reg, a_x_next;
    logic [DW-1:0]     a_y_reg, a_y_next;
    logic [cfb_pkg::PIX_W-1:0] a_data_reg, a_data_next;

    logic              accept;
    logic              pos_in;
    logic              area_ok;
    logic [DW-1:0]     w_rem, h_rem;
    logic [DW-1:0]     clip_w, clip_h;
    logic              bp_in_clip;
    logic [DW:0]       bp_tx, bp_ty;
    logic              bp_in;
    logic [CW-1:0]     col_inc, row_inc;

    assign s_ready = !fill_busy_reg && credit_ok;
    assign accept  = s_valid && s_ready;

    assign pos_in  = cfg.ok && (s_pos_x < CW'(cfg.width)) && (s_pos_y < CW'(cfg.height));
    assign area_ok = pos_in && (s_rect_w != '0) && (s_rect_h != '0);
    assign w_rem   = cfg.width - s_pos_x[DW-1:0];
    assign h_rem   = cfg.height - s_pos_y[DW-1:0];
    assign clip_w  = (s_rect_w > CW'(w_rem)) ? w_rem : s_rect_w[DW-1:0];
    assign clip_h  = (s_rect_h > CW'(h_rem)) ? h_rem : s_rect_h[DW-1:0];

    assign bp_in_clip = (blit_col_reg < CW'(blit_cw_reg)) && (blit_row_reg < CW'(blit_ch_reg));
    assign bp_tx = (DW+1)'(blit_dx_reg) + (DW+1)'(blit_col_reg[DW-1:0]);
    assign bp_ty = (DW+1)'(blit_dy_reg) + (DW+1)'(blit_row_reg[DW-1:0]);
    assign bp_in = cfg.ok && bp_in_clip && (bp_tx < (DW+1)'(cfg.width))
                   && (bp_ty < (DW+1)'(cfg.height));
    assign col_inc = blit_col_reg + CW'(1);
    assign row_inc = blit_row_reg + CW'(1);

    always_comb begin
        fill_busy_next   = fill_busy_reg;
        fill_x_next      = fill_x_reg;
        fill_y_next      = fill_y_reg;
        fill_w_next      = fill_w_reg;
        fill_h_next      = fill_h_reg;
        fill_c_next      = fill_c_reg;
        fill_r_next      = fill_r_reg;
        fill_pix_next    = fill_pix_reg;
        blit_active_next = blit_active_reg;
        blit_dx_next     = blit_dx_reg;
        blit_dy_next     = blit_dy_reg;
        blit_sw_next     = blit_sw_reg;
        blit_sh_next     = blit_sh_reg;
        blit_cw_next     = blit_cw_reg;
        blit_ch_next     = blit_ch_reg;
        blit_row_next    = blit_row_reg;
        blit_col_next    = blit_col_reg;
        a_ctl_next.op    = cfb_pkg::OP_NONE;
        a_ctl_next.hit   = 1'b0;
        a_x_next         = '0;
        a_y_next         = '0;
        a_data_next      = s_pixel_value;

        if (fill_busy_reg) begin
            a_ctl_next.op  = cfb_pkg::OP_WRITE;
            a_ctl_next.hit = 1'b1;
            a_x_next       = fill_x_reg + fill_c_reg;
            a_y_next       = fill_y_reg + fill_r_reg;
            a_data_next    = fill_pix_reg;
            if (fill_c_reg == fill_w_reg - DW'(1)) begin
                fill_c_next = '0;
                if (fill_r_reg == fill_h_reg - DW'(1)) begin
                    fill_busy_next = 1'b0;
                end else begin
                    fill_r_next = fill_r_reg + DW'(1);
                end
            end else begin
                fill_c_next = fill_c_reg + DW'(1);
            end
        end else if (accept) begin
            unique case (s_kind)
                cfb_pkg::KIND_PUT: begin
                    if (pos_in) begin
                        a_ctl_next.op  = cfb_pkg::OP_WRITE;
                        a_ctl_next.hit = 1'b1;
                        a_x_next       = s_pos_x[DW-1:0];
                        a_y_next       = s_pos_y[DW-1:0];
                    end
                end
                cfb_pkg::KIND_FILL: begin
                    if (area_ok) begin
                        fill_busy_next = 1'b1;
                        fill_x_next    = s_pos_x[DW-1:0];
                        fill_y_next    = s_pos_y[DW-1:0];
                        fill_w_next    = clip_w;
                        fill_h_next    = clip_h;
                        fill_c_next    = '0;
                        fill_r_next    = '0;
                        fill_pix_next  = s_pixel_value;
                    end
                end
                cfb_pkg::KIND_BLIT_START: begin
                    blit_active_next = area_ok;
                    if (area_ok) begin
                        blit_dx_next  = s_pos_x[cfb_pkg::DEST_W-1:0];
                        blit_dy_next  = s_pos_y[cfb_pkg::DEST_W-1:0];
                        blit_sw_next  = s_rect_w;
                        blit_sh_next  = s_rect_h;
                        blit_cw_next  = clip_w;
                        blit_ch_next  = clip_h;
                        blit_row_next = '0;
                        blit_col_next = '0;
                    end
                end
                cfb_pkg::KIND_BLIT_PIX: begin
                    if (blit_active_reg) begin
                        if (bp_in) begin
                            a_ctl_next.op  = cfb_pkg::OP_WRITE;
                            a_ctl_next.hit = 1'b1;
                            a_x_next       = bp_tx[DW-1:0];
                            a_y_next       = bp_ty[DW-1:0];
                        end
                        if (col_inc == blit_sw_reg) begin
                            blit_col_next = '0;
                            blit_row_next = row_inc;
                            if (row_inc == blit_sh_reg) begin
                                blit_active_next = 1'b0;
                            end
                        end else begin
                            blit_col_next = col_inc;
                        end
                    end
                end
                cfb_pkg::KIND_READ: begin
                    a_ctl_next.op  = cfb_pkg::OP_READ;
                    a_ctl_next.hit = pos_in;
                    if (pos_in) begin
                        a_x_next = s_pos_x[DW-1:0];
                        a_y_next = s_pos_y[DW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_busy_reg   <= 1'b0;
            fill_c_reg      <= '0;
            fill_r_reg      <= '0;
            blit_active_reg <= 1'b0;
            blit_dx_reg     <= '0;
            blit_dy_reg     <= '0;
            blit_sw_reg     <= '0;
            blit_sh_reg     <= '0;
            blit_cw_reg     <= '0;
            blit_ch_reg     <= '0;
            blit_row_reg    <= '0;
            blit_col_reg    <= '0;
            a_ctl_reg       <= '0;
        end else begin
            fill_busy_reg   <= fill_busy_next;
            fill_c_reg      <= fill_c_next;
            fill_r_reg      <= fill_r_next;
            blit_active_reg <= blit_active_next;
            blit_dx_reg     <= blit_dx_next;
            blit_dy_reg     <= blit_dy_next;
            blit_sw_reg     <= blit_sw_next;
            blit_sh_reg     <= blit_sh_next;
            blit_cw_reg     <= blit_cw_next;
            blit_ch_reg     <= blit_ch_next;
            blit_row_reg    <= blit_row_next;
            blit_col_reg    <= blit_col_next;
            a_ctl_reg       <= a_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_x_reg   <= fill_x_next;
        fill_y_reg   <= fill_y_next;
        fill_w_reg   <= fill_w_next;
        fill_h_reg   <= fill_h_next;
        fill_pix_reg <= fill_pix_next;
        a_x_reg      <= a_x_next;
        a_y_reg      <= a_y_next;
        a_data_reg   <= a_data_next;
    end

    assign a_ctl  = a_ctl_reg;
    assign a_x    = a_x_reg;
    assign a_y    = a_y_reg;
    assign a_data = a_data_reg;

endmodule

// ===== rtl/core/cfb_addr.sv =====
// Address stage: store address = y * row_stride + x, registered.
// Depends on cfb_pkg.
module cfb_addr #(
    parameter int MAX_STRIDE = cfb_pkg::MAX_STRIDE_DEF,
    parameter int MAX_HEIGHT = cfb_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W     = $clog2(MAX_STRIDE * MAX_HEIGHT)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [cfb_pkg::DIM_W-1:0] stride,
    input  cfb_pkg::cfb_ctl_t         a_ctl,
    input  logic [cfb_pkg::DIM_W-1:0] a_x,
    input  logic [cfb_pkg::DIM_W-1:0] a_y,
    input  logic [cfb_pkg::PIX_W-1:0] a_data,
    output cfb_pkg::cfb_ctl_t         b_ctl,
    output logic [ADDR_W-1:0]         b_addr,
    output logic [cfb_pkg::PIX_W-1:0] b_data
);

    localparam int PW = 2 * cfb_pkg::DIM_W + 1;

    logic [PW-1:0]             lin_addr;
    cfb_pkg::cfb_ctl_t         b_ctl_reg;
    logic [ADDR_W-1:0]         b_addr_reg, b_addr_next;
    logic [cfb_pkg::PIX_W-1:0] b_data_reg;

    assign lin_addr    = PW'(a_y) * PW'(stride) + PW'(a_x);
    assign b_addr_next = ADDR_W'(lin_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctl_reg <= '0;
        end else begin
            b_ctl_reg <= a_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        b_addr_reg <= b_addr_next;
        b_data_reg <= a_data;
    end

    assign b_ctl  = b_ctl_reg;
    assign b_addr = b_addr_reg;
    assign b_data = b_data_reg;

endmodule

// ===== rtl/core/cfb_store.sv =====
// Pixel store: single write / single read synchronous memory with a registered read.
// Depends on cfb_pkg.
module cfb_store #(
    parameter int MAX_STRIDE = cfb_pkg::MAX_STRIDE_DEF,
    parameter int MAX_HEIGHT = cfb_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W     = $clog2(MAX_STRIDE * MAX_HEIGHT)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfb_pkg::cfb_ctl_t         b_ctl,
    input  logic [ADDR_W-1:0]         b_addr,
    input  logic [cfb_pkg::PIX_W-1:0] b_data,
    output logic                      rd_valid,
    output logic                      rd_inside,
    output logic [cfb_pkg::PIX_W-1:0] rd_data
);

    localparam int DEPTH = MAX_STRIDE * MAX_HEIGHT;

    logic [cfb_pkg::PIX_W-1:0] mem [DEPTH];
    logic                      rd_valid_reg;
    logic                      rd_inside_reg;
    logic [cfb_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (b_ctl.op == cfb_pkg::OP_WRITE) begin
            mem[b_addr] <= b_data;
        end
        if (b_ctl.op == cfb_pkg::OP_READ && b_ctl.hit) begin
            rd_data_reg <= mem[b_addr];
        end
        rd_inside_reg <= b_ctl.hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (b_ctl.op == cfb_pkg::OP_READ);
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_inside = rd_inside_reg;
    assign rd_data   = rd_data_reg;

endmodule

// ===== rtl/core/cfb_outq.sv =====
// Result queue between the store read port and the m_ channel.
// Depends on cfb_pkg.
module cfb_outq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic                      push_inside,
    input  logic [cfb_pkg::PIX_W-1:0] push_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [cfb_pkg::PIX_W-1:0] m_read_value,
    output logic                      m_read_inside
);

    localparam int PTR_W = $clog2(cfb_pkg::OUT_DEPTH);
    localparam int CNT_W = $clog2(cfb_pkg::OUT_DEPTH + 1);

    logic [cfb_pkg::PIX_W-1:0] val_q [cfb_pkg::OUT_DEPTH];
    logic                      ins_q [cfb_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      pop;

    assign m_valid       = (count_reg != '0);
    assign pop           = m_valid && m_ready;
    assign m_read_value  = val_q[rd_ptr_reg];
    assign m_read_inside = ins_q[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cfb_pkg::OUT_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cfb_pkg::OUT_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        priority if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            val_q[wr_ptr_reg] <= push_inside ? push_data : '0;
            ins_q[wr_ptr_reg] <= push_inside;
        end
    end

endmodule

// ===== test/tb_clipped_fill_blit_framebuffer_top.sv =====
// Self-checking testbench for clipped_fill_blit_framebuffer_top: put, fill, blit
// and read traffic against a pixel store predictor, with random stalls and reframing.
// Depends on cfb_pkg and the RTL under rtl/core.
module tb_clipped_fill_blit_framebuffer_top;

    localparam int SETTLE      = 8;
    localparam int STORE_WORDS = cfb_pkg::MAX_STRIDE_DEF * cfb_pkg::MAX_HEIGHT_DEF;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int RUN_LIMIT   = 16_000_000;

    localparam logic [cfb_pkg::KIND_W-1:0]    KIND_RSVD5 = 3'd5;
    localparam logic [cfb_pkg::KIND_W-1:0]    KIND_RSVD7 = 3'd7;
    localparam logic [cfb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN} pending_kind_t;

    typedef struct {
        pending_kind_t                   op;
        logic [cfb_pkg::KIND_W-1:0]      kind;
        logic [cfb_pkg::COORD_W-1:0]     x;
        logic [cfb_pkg::COORD_W-1:0]     y;
        logic [cfb_pkg::COORD_W-1:0]     w;
        logic [cfb_pkg::COORD_W-1:0]     h;
        logic [cfb_pkg::PIX_W-1:0]       pv;
        logic [cfb_pkg::CFG_IDX_W-1:0]   idx;
        logic [cfb_pkg::DIM_W-1:0]       data;
        int                              idle_pct;
        bit                              quiet;
    } pending_op_t;

    typedef struct packed {
        logic [cfb_pkg::PIX_W-1:0] rd_value;
        logic                      rd_inside;
    } read_result_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [cfb_pkg::DIM_W-1:0]     cfg_wdata     = '0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [cfb_pkg::KIND_W-1:0]    s_kind        = '0;
    logic [cfb_pkg::COORD_W-1:0]   s_pos_x       = '0;
    logic [cfb_pkg::COORD_W-1:0]   s_pos_y       = '0;
    logic [cfb_pkg::COORD_W-1:0]   s_rect_w      = '0;
    logic [cfb_pkg::COORD_W-1:0]   s_rect_h      = '0;
    logic [cfb_pkg::PIX_W-1:0]     s_pixel_value = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic [cfb_pkg::PIX_W-1:0]     m_read_value;
    logic                          m_read_inside;

    clipped_fill_blit_framebuffer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_rect_w      (s_rect_w),
        .s_rect_h      (s_rect_h),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_read_inside (m_read_inside)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // stimulus queue and generator state
    pending_op_t  pending_ops[$];
    int           gen_w     = 256;
    int           gen_h     = 256;
    int           gen_idle  = 20;
    bit           gen_quiet = 1'b0;

    // predicted pixel store and engine state
    logic [cfb_pkg::PIX_W-1:0]   pix_mem [STORE_WORDS];
    logic [cfb_pkg::DIM_W-1:0]   fb_width  = cfb_pkg::DIM_RESET;
    logic [cfb_pkg::DIM_W-1:0]   fb_height = cfb_pkg::DIM_RESET;
    logic [cfb_pkg::DIM_W-1:0]   fb_stride = cfb_pkg::DIM_RESET;
    bit                          blit_on   = 1'b0;
    logic [cfb_pkg::DEST_W-1:0]  blit_dx   = '0;
    logic [cfb_pkg::DEST_W-1:0]  blit_dy   = '0;
    logic [cfb_pkg::COORD_W-1:0] blit_sw   = '0;
    logic [cfb_pkg::COORD_W-1:0] blit_sh   = '0;
    logic [cfb_pkg::DIM_W-1:0]   blit_cw   = '0;
    logic [cfb_pkg::DIM_W-1:0]   blit_ch   = '0;
    logic [cfb_pkg::COORD_W-1:0] blit_row  = '0;
    logic [cfb_pkg::COORD_W-1:0] blit_col  = '0;

    read_result_t read_results_due[$];
    int           pending_reads = 0;
    int           mismatches    = 0;
    int           drv_gap       = 0;
    int           drv_calm      = 0;
    int           sink_stall    = 0;
    bit           stim_done     = 1'b0;
    bit           tail_quiet    = 1'b0;

    function automatic void push_item(input logic [cfb_pkg::KIND_W-1:0] k,
                                      input int unsigned x, input int unsigned y,
                                      input int unsigned w, input int unsigned h,
                                      input logic [cfb_pkg::PIX_W-1:0] pv);
        pending_op_t e;
        e.op       = ENT_ITEM;
        e.kind     = k;
        e.x        = x[cfb_pkg::COORD_W-1:0];
        e.y        = y[cfb_pkg::COORD_W-1:0];
        e.w        = w[cfb_pkg::COORD_W-1:0];
        e.h        = h[cfb_pkg::COORD_W-1:0];
        e.pv       = pv;
        e.idle_pct = gen_idle;
        e.quiet    = gen_quiet;
        pending_ops.push_back(e);
    endfunction

    function automatic void push_cfg(input logic [cfb_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [cfb_pkg::DIM_W-1:0] data);
        pending_op_t e;
        e.op       = ENT_CFG;
        e.idx      = idx;
        e.data     = data;
        e.idle_pct = gen_idle;
        e.quiet    = gen_quiet;
        pending_ops.push_back(e);
    endfunction

    function automatic void push_drain();
        pending_op_t e;
        e.op       = ENT_DRAIN;
        e.idle_pct = gen_idle;
        e.quiet    = gen_quiet;
        pending_ops.push_back(e);
    endfunction

    function automatic void set_frame(input int w, input int h, input int s);
        gen_w = w;
        gen_h = h;
        push_cfg(cfb_pkg::CFG_STRIDE, s[cfb_pkg::DIM_W-1:0]);
        push_cfg(cfb_pkg::CFG_WIDTH, w[cfb_pkg::DIM_W-1:0]);
        push_cfg(cfb_pkg::CFG_HEIGHT, h[cfb_pkg::DIM_W-1:0]);
    endfunction

    // half near or just past the frame edges, otherwise mostly inside, rarely anywhere
    function automatic int unsigned pick_coord(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom & 32'hFFFF;
        if (lim == 0)
            return $urandom_range(0, 3);
        if (r < 4)
            return lim - $urandom_range(1, (lim < 6) ? lim : 6);
        if (r < 6)
            return $urandom_range(lim, lim + 3);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic gen_phase(input int n_items, input bit add_drain);
        int unsigned                bx, by, x, y, kr;
        int                         done, pick, bw, bh, n, i;
        bit                         drained;
        logic [cfb_pkg::KIND_W-1:0] k;
        done    = 0;
        drained = 1'b0;
        while (done < n_items) begin
            if (add_drain && !drained && done >= n_items / 2) begin
                push_drain();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                push_item(cfb_pkg::KIND_PUT, pick_coord(gen_w), pick_coord(gen_h),
                          $urandom, $urandom, $urandom);
                done++;
            end else if (pick < 50) begin
                push_item(cfb_pkg::KIND_READ, pick_coord(gen_w), pick_coord(gen_h),
                          $urandom, $urandom, $urandom);
                done++;
            end else if (pick < 65) begin
                push_item(cfb_pkg::KIND_FILL, pick_coord(gen_w), pick_coord(gen_h),
                          $urandom_range(0, 8), $urandom_range(0, 6), $urandom);
                done++;
            end else if (pick < 85) begin
                bw = $urandom_range(1, 6);
                bh = $urandom_range(1, 4);
                bx = pick_coord(gen_w);
                by = pick_coord(gen_h);
                push_item(cfb_pkg::KIND_BLIT_START, bx, by, bw, bh, $urandom);
                n = bw * bh + $urandom_range(0, 2);
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(0, bw * bh);
                for (i = 0; i < n; i++)
                    push_item(cfb_pkg::KIND_BLIT_PIX, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                push_item(cfb_pkg::KIND_READ, bx + $urandom_range(0, bw),
                          by + $urandom_range(0, bh), $urandom, $urandom, $urandom);
                push_item(cfb_pkg::KIND_READ, bx + $urandom_range(0, bw),
                          by + $urandom_range(0, bh), $urandom, $urandom, $urandom);
                done += n + 3;
            end else begin
                kr = $urandom_range(0, 7);
                k  = kr[cfb_pkg::KIND_W-1:0];
                x  = $urandom;
                y  = $urandom;
                // keep wide noise fills in the bottom-right corner so they clip small
                if (k == cfb_pkg::KIND_FILL && gen_w > 0 && gen_h > 0) begin
                    x = gen_w - $urandom_range(1, (gen_w < 4) ? gen_w : 4);
                    y = gen_h - $urandom_range(1, (gen_h < 4) ? gen_h : 4);
                end
                push_item(k, x, y, $urandom, $urandom, $urandom);
                done++;
            end
        end
    endtask

    function automatic bit frame_ok();
        return fb_width != 0 && fb_height != 0 && fb_stride >= fb_width &&
               fb_stride <= cfb_pkg::MAX_STRIDE_DEF && fb_height <= cfb_pkg::MAX_HEIGHT_DEF;
    endfunction

    function automatic bit in_frame(input int unsigned x, input int unsigned y);
        return frame_ok() && x < fb_width && y < fb_height;
    endfunction

    function automatic int unsigned pix_addr(input int unsigned x, input int unsigned y);
        return y * fb_stride + x;
    endfunction

    task automatic store_px(input int unsigned x, input int unsigned y,
                            input logic [cfb_pkg::PIX_W-1:0] v);
        int unsigned a;
        if (in_frame(x, y)) begin
            a = pix_addr(x, y);
            if (a < STORE_WORDS)
                pix_mem[a[STORE_AW-1:0]] = v;
        end
    endtask

    task automatic draw_and_read(input logic [cfb_pkg::KIND_W-1:0] k,
                                 input logic [cfb_pkg::COORD_W-1:0] px,
                                 input logic [cfb_pkg::COORD_W-1:0] py,
                                 input logic [cfb_pkg::COORD_W-1:0] pw,
                                 input logic [cfb_pkg::COORD_W-1:0] ph,
                                 input logic [cfb_pkg::PIX_W-1:0] pv,
                                 output bit is_read, output read_result_t res);
        int unsigned ux, uy, uw, uh, tx, ty, r, c, cw, ch, a;
        ux            = px;
        uy            = py;
        uw            = pw;
        uh            = ph;
        is_read       = 1'b0;
        res.rd_value  = '0;
        res.rd_inside = 1'b0;
        unique case (k)
            cfb_pkg::KIND_PUT: begin
                store_px(ux, uy, pv);
            end
            cfb_pkg::KIND_FILL: begin
                if (uw != 0 && uh != 0 && in_frame(ux, uy)) begin
                    if (uw > fb_width - ux)
                        uw = fb_width - ux;
                    if (uh > fb_height - uy)
                        uh = fb_height - uy;
                    for (r = 0; r < uh; r++)
                        for (c = 0; c < uw; c++)
                            store_px(ux + c, uy + r, pv);
                end
            end
            cfb_pkg::KIND_BLIT_START: begin
                blit_on = 1'b0;
                if (uw != 0 && uh != 0 && in_frame(ux, uy)) begin
                    cw       = (uw > fb_width - ux) ? fb_width - ux : uw;
                    ch       = (uh > fb_height - uy) ? fb_height - uy : uh;
                    blit_on  = 1'b1;
                    blit_dx  = px[cfb_pkg::DEST_W-1:0];
                    blit_dy  = py[cfb_pkg::DEST_W-1:0];
                    blit_sw  = pw;
                    blit_sh  = ph;
                    blit_cw  = cw[cfb_pkg::DIM_W-1:0];
                    blit_ch  = ch[cfb_pkg::DIM_W-1:0];
                    blit_row = '0;
                    blit_col = '0;
                end
            end
            cfb_pkg::KIND_BLIT_PIX: begin
                if (blit_on) begin
                    if (blit_row < blit_ch && blit_col < blit_cw) begin
                        tx = blit_dx;
                        ty = blit_dy;
                        store_px(tx + blit_col, ty + blit_row, pv);
                    end
                    blit_col = blit_col + 1'b1;
                    if (blit_col >= blit_sw) begin
                        blit_col = '0;
                        blit_row = blit_row + 1'b1;
                        if (blit_row >= blit_sh)
                            blit_on = 1'b0;
                    end
                end
            end
            cfb_pkg::KIND_READ: begin
                is_read = 1'b1;
                if (in_frame(ux, uy)) begin
                    a             = pix_addr(ux, uy);
                    res.rd_value  = pix_mem[a[STORE_AW-1:0]];
                    res.rd_inside = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    // sender: one transfer at a time from pending_ops; frame writes and drains wait for idle
    always @(posedge aclk) begin : drive_proc
        pending_op_t nxt;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
            drv_gap   = 0;
            drv_calm  = 0;
        end else begin
            if (pending_reads == 0 && !s_valid && !cfg_valid && s_ready && !m_valid)
                drv_calm = drv_calm + 1;
            else
                drv_calm = 0;
            if ((s_valid && !s_ready) || (cfg_valid && !cfg_ready)) begin
            end else if (drv_gap > 0) begin
                drv_gap   = drv_gap - 1;
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (pending_ops[0].op != ENT_ITEM && drv_calm < SETTLE) begin
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
            end else begin
                nxt = pending_ops.pop_front();
                tail_quiet <= nxt.quiet;
                unique case (nxt.op)
                    ENT_ITEM: begin
                        s_kind        <= nxt.kind;
                        s_pos_x       <= nxt.x;
                        s_pos_y       <= nxt.y;
                        s_rect_w      <= nxt.w;
                        s_rect_h      <= nxt.h;
                        s_pixel_value <= nxt.pv;
                        s_valid       <= 1'b1;
                        cfg_valid     <= 1'b0;
                        if (!nxt.quiet && $urandom_range(0, 99) < nxt.idle_pct)
                            drv_gap = $urandom_range(1, 16);
                    end
                    ENT_CFG: begin
                        cfg_index <= nxt.idx;
                        cfg_wdata <= nxt.data;
                        cfg_valid <= 1'b1;
                        s_valid   <= 1'b0;
                        drv_calm  = 0;
                    end
                    default: begin
                        s_valid   <= 1'b0;
                        cfg_valid <= 1'b0;
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (tail_quiet) begin
            m_ready <= 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 99) < 10) begin
            sink_stall = $urandom_range(0, 15);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // predictor and result check; results are matched before a new read is queued
    always @(posedge aclk) begin : check_proc
        read_result_t want;
        bit           is_read;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (read_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %h inside %b",
                             $time, m_read_value, m_read_inside);
                    mismatches++;
                end else begin
                    want = read_results_due.pop_front();
                    if (m_read_value !== want.rd_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.rd_value, m_read_value);
                        mismatches++;
                    end
                    if (m_read_inside !== want.rd_inside) begin
                        $display("%0t: read_inside expected %b actual %b",
                                 $time, want.rd_inside, m_read_inside);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    cfb_pkg::CFG_WIDTH:  fb_width  = cfg_wdata;
                    cfb_pkg::CFG_HEIGHT: fb_height = cfg_wdata;
                    cfb_pkg::CFG_STRIDE: fb_stride = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                draw_and_read(s_kind, s_pos_x, s_pos_y, s_rect_w, s_rect_h, s_pixel_value,
                              is_read, want);
                if (is_read)
                    read_results_due.push_back(want);
            end
            pending_reads <= read_results_due.size();
        end
    end

    initial begin
        int i;
        // full-frame fill first so every store word is defined before any read
        push_item(cfb_pkg::KIND_FILL, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_item(cfb_pkg::KIND_PUT, 255, 255, 0, 0, 32'h0000_0000);
        push_item(cfb_pkg::KIND_PUT, 0, 0, 16'hFFFF, 16'hFFFF, 32'hDEAD_BEEF);
        push_item(cfb_pkg::KIND_PUT, 256, 5, 0, 0, 32'h0000_0001);
        push_item(cfb_pkg::KIND_PUT, 7, 16'hFFFF, 0, 0, 32'h0000_0002);
        push_item(cfb_pkg::KIND_FILL, 3, 3, 0, 4, 32'h0000_0003);
        push_item(cfb_pkg::KIND_FILL, 3, 3, 4, 0, 32'h0000_0004);
        push_item(cfb_pkg::KIND_FILL, 256, 0, 4, 4, 32'h0000_0005);
        push_item(cfb_pkg::KIND_FILL, 250, 253, 16'hFFFF, 5, 32'h1234_5678);
        push_item(cfb_pkg::KIND_BLIT_START, 254, 255, 3, 2, 32'h0);
        for (i = 0; i < 7; i++)
            push_item(cfb_pkg::KIND_BLIT_PIX, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_item(cfb_pkg::KIND_BLIT_START, 9, 9, 0, 3, 32'h0);
        push_item(cfb_pkg::KIND_BLIT_PIX, 0, 0, 0, 0, 32'hBAD0_0001);
        push_item(KIND_RSVD5, 1, 1, 1, 1, 32'h5555_5555);
        push_item(KIND_RSVD7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA);
        push_item(cfb_pkg::KIND_READ, 255, 255, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 254, 255, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 255, 254, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 0, 0, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 256, 5, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 16'hFFFF, 16'hFFFF, 0, 0, 32'h0);
        // replaced blit, then a frame change in the middle of the second one
        push_item(cfb_pkg::KIND_BLIT_START, 2, 0, 6, 2, 32'h0);
        for (i = 0; i < 3; i++)
            push_item(cfb_pkg::KIND_BLIT_PIX, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_item(cfb_pkg::KIND_BLIT_START, 0, 1, 8, 2, 32'h0);
        for (i = 0; i < 2; i++)
            push_item(cfb_pkg::KIND_BLIT_PIX, $urandom, $urandom, $urandom, $urandom, $urandom);
        set_frame(5, 256, 256);
        push_cfg(CFG_UNUSED, 9'h1AA);
        for (i = 0; i < 14; i++)
            push_item(cfb_pkg::KIND_BLIT_PIX, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_item(cfb_pkg::KIND_READ, 1, 1, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 4, 1, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 2, 0, 0, 0, 32'h0);
        push_item(cfb_pkg::KIND_READ, 6, 1, 0, 0, 32'h0);

        gen_phase(85, 1'b0);
        gen_idle = 50;
        set_frame(16, 12, 20);
        gen_phase(85, 1'b1);
        gen_idle = 0;
        set_frame(1, 1, 1);
        gen_phase(85, 1'b0);
        gen_idle = 20;
        set_frame(0, 8, 8);
        gen_phase(85, 1'b0);
        gen_idle = 50;
        set_frame(200, 130, 211);
        gen_phase(85, 1'b1);
        gen_idle = 20;
        set_frame(20, 10, 15);
        gen_phase(85, 1'b0);
        gen_idle = 0;
        set_frame(12, 0, 16);
        gen_phase(85, 1'b0);
        gen_idle = 50;
        set_frame(256, 256, 256);
        gen_phase(85, 1'b1);
        gen_idle = 20;
        set_frame(8, 8, 0);
        gen_phase(85, 1'b0);
        gen_idle  = 0;
        gen_quiet = 1'b1;
        set_frame(24, 24, 32);
        gen_phase(85, 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && pending_reads == 0))
            @(negedge aclk);
        repeat (SETTLE * 2) @(negedge aclk);
        if (mismatches == 0 && read_results_due.size() == 0) begin
            $display("clipped_fill_blit_framebuffer_top verification clean");
        end else begin
            $display("clipped_fill_blit_framebuffer_top verification failed");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("clipped_fill_blit_framebuffer_top verification failed");
        $finish;
    end

endmodule
